// ----- rtl/core/bbc_pkg.sv -----
package bbc_pkg;

  // Latched error / verdict codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MISMATCH = 3'd1;
  localparam logic [2:0] ERR_EMPTY    = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Bracket kinds as kept in the stack
  localparam logic [1:0] KIND_PAREN = 2'd0;
  localparam logic [1:0] KIND_BRACE = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
  localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
  localparam logic [7:0] CHAR_RSQUARE = 8'h5D;

  // Shift control handed from the controller to the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

  function automatic logic is_opener(input logic [7:0] c);
    is_opener = (c == CHAR_LPAREN) || (c == CHAR_LBRACE) || (c == CHAR_LSQUARE);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    is_closer = (c == CHAR_RPAREN) || (c == CHAR_RBRACE) || (c == CHAR_RSQUARE);
  endfunction

  // Kind of a bracket character, opener or closer
  function automatic logic [1:0] bracket_kind(input logic [7:0] c);
    case (c)
      CHAR_LPAREN, CHAR_RPAREN:   bracket_kind = KIND_PAREN;
      CHAR_LBRACE, CHAR_RBRACE:   bracket_kind = KIND_BRACE;
      CHAR_LSQUARE, CHAR_RSQUARE: bracket_kind = KIND_SQUARE;
      default:                    bracket_kind = KIND_PAREN;
    endcase
  endfunction

endpackage

// ----- rtl/core/bbc_cell.sv -----
module bbc_cell (
  input  logic                 clk,
  input  bbc_pkg::shift_ctrl_t ctrl,
  input  logic [1:0]           from_above,
  input  logic [1:0]           from_below,
  output logic [1:0]           kind
);

  // Push moves entries down the row, pop moves them up
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      kind <= from_above;
    end else if (ctrl.pop) begin
      kind <= from_below;
    end
  end

endmodule

// ----- rtl/core/bbc_ctrl.sv -----
module bbc_ctrl #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           character,
  input  logic                 last,
  input  logic [1:0]           top_kind,
  output bbc_pkg::shift_ctrl_t ctrl,
  output logic [1:0]           push_kind,
  output logic                 res_valid,
  output logic [2:0]           verdict
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [2:0]    first_error;
  logic [2:0]    first_error_next;
  logic          opener;
  logic          closer;
  logic [1:0]    kind;

  assign opener    = bbc_pkg::is_opener(character);
  assign closer    = bbc_pkg::is_closer(character);
  assign kind      = bbc_pkg::bracket_kind(character);
  assign push_kind = kind;

  // Judge the current character against count and top of stack
  always_comb begin
    ctrl             = '0;
    count_next       = count;
    first_error_next = first_error;
    if (accept && (first_error == bbc_pkg::ERR_NONE)) begin
      if (opener) begin
        if (count == CW'(STACK_DEPTH)) begin
          first_error_next = bbc_pkg::ERR_OVERFLOW;
        end else begin
          ctrl.push  = 1'b1;
          count_next = count + CW'(1);
        end
      end else if (closer) begin
        if (count == '0) begin
          first_error_next = bbc_pkg::ERR_EMPTY;
        end else begin
          ctrl.pop   = 1'b1;
          count_next = count - CW'(1);
          if (top_kind != kind) begin
            first_error_next = bbc_pkg::ERR_MISMATCH;
          end
        end
      end
    end
  end

  // Verdict: latched error first, then leftover openers
  always_comb begin
    if (first_error_next != bbc_pkg::ERR_NONE) begin
      verdict = first_error_next;
    end else if (count_next != '0) begin
      verdict = bbc_pkg::ERR_UNCLOSED;
    end else begin
      verdict = bbc_pkg::ERR_NONE;
    end
  end

  assign res_valid = accept && last;

  // End of string returns to the reset state
  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      count       <= '0;
      first_error <= bbc_pkg::ERR_NONE;
    end else begin
      count       <= count_next;
      first_error <= first_error_next;
    end
  end

endmodule

// ----- rtl/core/bracket_balance_checker.sv -----
// Bracket balance checker: one character per cycle, stack held in a row of shift cells.
// Result path: the verdict of the final character is registered into the output register (m_tvalid),
// or into the skid entry when an older verdict is still held there and not taken.
// Throughput: one character per cycle; the two-entry output buffer stalls input only
// when two verdicts are waiting downstream.
// Reset (rst, synchronous): clears count, latched error and output buffer; no clearing pass.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] verdict, [3] balanced, [7:4] zero
);

  logic                 in_accept;
  bbc_pkg::shift_ctrl_t ctrl;
  logic [1:0]           push_kind;
  logic                 res_valid;
  logic [2:0]           verdict;
  logic [1:0]           kinds [STACK_DEPTH];
  logic [3:0]           res_word;
  logic                 out_valid;
  logic [3:0]           out_word;
  logic                 skid_valid;
  logic [3:0]           skid_word;

  assign in_accept = s_tvalid && s_tready;

  // Push/pop decisions, count and error latch
  bbc_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .character (s_tdata),
    .last      (s_tlast),
    .top_kind  (kinds[0]),
    .ctrl      (ctrl),
    .push_kind (push_kind),
    .res_valid (res_valid),
    .verdict   (verdict)
  );

  // Stack as a row of cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [1:0] above;
    logic [1:0] below;
    if (i == 0) begin : g_top
      assign above = push_kind;
    end else begin : g_mid
      assign above = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = kinds[i];
    end else begin : g_up
      assign below = kinds[i+1];
    end
    bbc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .kind       (kinds[i])
    );
  end

  assign res_word = {(verdict == bbc_pkg::ERR_NONE), verdict};

  // Output register with one skid entry
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= res_word;
      end else begin
        out_word <= res_word;
      end
    end else if (res_valid) begin
      skid_word <= res_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_word};

  // Skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // Stack never pushes and pops in one cycle
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("stack push and pop together");

  // The output is valid on the cycle after a final character is accepted
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tlast) |=> out_valid)
    else $error("final character gave no verdict");

  // A balanced flag always agrees with the verdict code
  a_balanced_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word[3] == (out_word[2:0] == bbc_pkg::ERR_NONE)))
    else $error("balanced flag disagrees with verdict");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int STACK_DEPTH = 128;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int RANDOM_ITEMS = 240;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] character
  logic       s_tlast = 1'b0;   // last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [2:0] verdict, [3] balanced, [7:4] zero

  bracket_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Characters waiting to be sent, and verdicts waiting to arrive
  char_item_t pending_chars[$];
  logic [2:0] verdicts_due[$];

  // Shadow of the checker's state
  logic [1:0] open_kinds[$];
  logic [2:0] held_error = bbc_pkg::ERR_NONE;

  int mismatch_count = 0;
  int src_idle = 0;
  int src_calm = 0;
  int sink_stall = 0;
  int sink_calm = 0;
  char_item_t head_item;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // Gap length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] opener_char(input logic [1:0] kind);
    case (kind)
      bbc_pkg::KIND_PAREN: return bbc_pkg::CHAR_LPAREN;
      bbc_pkg::KIND_BRACE: return bbc_pkg::CHAR_LBRACE;
      default:             return bbc_pkg::CHAR_LSQUARE;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(input logic [1:0] kind);
    case (kind)
      bbc_pkg::KIND_PAREN: return bbc_pkg::CHAR_RPAREN;
      bbc_pkg::KIND_BRACE: return bbc_pkg::CHAR_RBRACE;
      default:             return bbc_pkg::CHAR_RSQUARE;
    endcase
  endfunction

  function automatic logic [1:0] rand_kind();
    case ($urandom_range(0, 2))
      0:       return bbc_pkg::KIND_PAREN;
      1:       return bbc_pkg::KIND_BRACE;
      default: return bbc_pkg::KIND_SQUARE;
    endcase
  endfunction

  // Mostly printable filler, sometimes any byte
  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // Update the shadow state with one accepted item; queue a verdict on the final one
  task automatic judge_char(input logic [7:0] ch, input logic fin);
    logic       is_open;
    logic       is_close;
    logic [1:0] kind;
    logic [1:0] top;
    logic [2:0] verdict;
    is_open = 1'b0;
    is_close = 1'b0;
    kind = bbc_pkg::KIND_PAREN;
    case (ch)
      bbc_pkg::CHAR_LPAREN:  begin is_open = 1'b1;  kind = bbc_pkg::KIND_PAREN;  end
      bbc_pkg::CHAR_LBRACE:  begin is_open = 1'b1;  kind = bbc_pkg::KIND_BRACE;  end
      bbc_pkg::CHAR_LSQUARE: begin is_open = 1'b1;  kind = bbc_pkg::KIND_SQUARE; end
      bbc_pkg::CHAR_RPAREN:  begin is_close = 1'b1; kind = bbc_pkg::KIND_PAREN;  end
      bbc_pkg::CHAR_RBRACE:  begin is_close = 1'b1; kind = bbc_pkg::KIND_BRACE;  end
      bbc_pkg::CHAR_RSQUARE: begin is_close = 1'b1; kind = bbc_pkg::KIND_SQUARE; end
      default: ;
    endcase
    // once an error is held, characters have no effect
    if (held_error == bbc_pkg::ERR_NONE) begin
      if (is_open) begin
        if (open_kinds.size() >= STACK_DEPTH) held_error = bbc_pkg::ERR_OVERFLOW;
        else open_kinds.push_back(kind);
      end else if (is_close) begin
        if (open_kinds.size() == 0) begin
          held_error = bbc_pkg::ERR_EMPTY;
        end else begin
          top = open_kinds.pop_back();
          if (top != kind) held_error = bbc_pkg::ERR_MISMATCH;
        end
      end
    end
    if (fin) begin
      if (held_error != bbc_pkg::ERR_NONE) verdict = held_error;
      else if (open_kinds.size() != 0) verdict = bbc_pkg::ERR_UNCLOSED;
      else verdict = bbc_pkg::ERR_NONE;
      verdicts_due.push_back(verdict);
      held_error = bbc_pkg::ERR_NONE;
      open_kinds.delete();
    end
  endtask

  task automatic check_verdict(input logic [7:0] word);
    logic [2:0] want;
    if (verdicts_due.size() == 0) begin
      $error("verdict: none expected, got %0d", word[2:0]);
      mismatch_count++;
    end else begin
      want = verdicts_due.pop_front();
      if (word[2:0] !== want) begin
        $error("verdict: expected %0d, got %0d", want, word[2:0]);
        mismatch_count++;
      end
      if (word[3] !== (want == bbc_pkg::ERR_NONE)) begin
        $error("balanced: expected %0d, got %0d", want == bbc_pkg::ERR_NONE, word[3]);
        mismatch_count++;
      end
      if (word[7:4] !== 4'd0) begin
        $error("pad: expected 0, got %0h", word[7:4]);
        mismatch_count++;
      end
    end
  endtask

  // Queue one string; the final character carries the last flag
  task automatic queue_text(input logic [7:0] text[$]);
    char_item_t it;
    for (int i = 0; i < text.size(); i++) begin
      it.ch = text[i];
      it.fin = (i == text.size() - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic add_literal(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    queue_text(text);
  endtask

  // Fill the stack to the top; either unwind it or push once more to overflow
  task automatic add_deep(input bit spill);
    logic [7:0] text[$];
    logic [1:0] kinds[$];
    logic [1:0] k;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      k = rand_kind();
      kinds.push_back(k);
      text.push_back(opener_char(k));
    end
    if (spill) begin
      text.push_back(opener_char(rand_kind()));
      // trailing closers are ignored once overflow is held
      for (int i = 0; i < 4; i++) text.push_back(closer_char(kinds.pop_back()));
    end else begin
      while (kinds.size() != 0) text.push_back(closer_char(kinds.pop_back()));
    end
    queue_text(text);
  endtask

  // Well-formed nesting with filler, sometimes broken on purpose
  task automatic add_random_string();
    logic [7:0] text[$];
    logic [1:0] nest[$];
    logic [1:0] k;
    int steps;
    int pos;
    int idx;
    steps = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
    for (int i = 0; i < steps; i++) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          k = rand_kind();
          nest.push_back(k);
          text.push_back(opener_char(k));
        end
        2, 3: if (nest.size() != 0) text.push_back(closer_char(nest.pop_back()));
        default: text.push_back(noise_char());
      endcase
    end
    while (nest.size() != 0) text.push_back(closer_char(nest.pop_back()));
    if (text.size() == 0) text.push_back(noise_char());

    case ($urandom_range(0, 9))
      // wrong closer kind
      6: begin
        pos = $urandom_range(0, text.size() - 1);
        for (int j = 0; j < text.size(); j++) begin
          idx = (pos + j) % text.size();
          if (text[idx] == bbc_pkg::CHAR_RPAREN) begin
            text[idx] = ($urandom_range(0, 1) != 0) ? bbc_pkg::CHAR_RBRACE
                                                    : bbc_pkg::CHAR_RSQUARE;
            break;
          end else if (text[idx] == bbc_pkg::CHAR_RBRACE) begin
            text[idx] = bbc_pkg::CHAR_RSQUARE;
            break;
          end else if (text[idx] == bbc_pkg::CHAR_RSQUARE) begin
            text[idx] = bbc_pkg::CHAR_RPAREN;
            break;
          end
        end
      end
      // cut the tail, usually leaving openers unclosed
      7: begin
        pos = $urandom_range(1, text.size());
        while (text.size() > pos) void'(text.pop_back());
      end
      // stray closer somewhere
      8: text.insert($urandom_range(0, text.size()), closer_char(rand_kind()));
      // raw bytes
      9: begin
        text.delete();
        steps = $urandom_range(1, 12);
        for (int i = 0; i < steps; i++) text.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    queue_text(text);
  endtask

  // Stimulus and end of run
  initial begin
    logic [7:0] extremes[$];
    int queued;
    int waited;

    add_literal("([{}])");
    add_literal("(]");
    add_literal(")");
    add_literal("((");
    add_literal("a");
    add_literal("{)x");
    add_literal("]()");
    add_literal("[}");
    add_literal("{");
    extremes.push_back(8'h00);
    extremes.push_back(8'hFF);
    queue_text(extremes);

    add_deep(1'b0);
    add_deep(1'b1);

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      waited = pending_chars.size();
      add_random_string();
      queued += pending_chars.size() - waited;
    end

    @(negedge rst);
    while (pending_chars.size() != 0 || s_tvalid) @(posedge clk);
    waited = 0;
    while (verdicts_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (verdicts_due.size() != 0) begin
      $error("verdict: %0d expected results never arrived", verdicts_due.size());
      mismatch_count++;
    end
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Source side: present queued items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) judge_char(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (src_idle > 0) begin
          src_idle--;
          s_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          head_item = pending_chars.pop_front();
          s_tdata <= head_item.ch;
          s_tlast <= head_item.fin;
          s_tvalid <= 1'b1;
          src_idle = pick_gap(src_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random stalls, check every accepted verdict
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_verdict(m_tdata);
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall = pick_gap(sink_calm);
      end
    end
  end

endmodule

// ----- sim.f -----
rtl/core/bbc_pkg.sv
rtl/core/bbc_cell.sv
rtl/core/bbc_ctrl.sv
rtl/core/bracket_balance_checker.sv
tb/testbench.sv
